FILE: rtl/core/imu_frx_pkg.sv
// Shared constants, types and helpers for the IMU frame receiver.
`timescale 1ns / 1ps
package imu_frx_pkg;

    // Framing bytes
    localparam logic [7:0] PREAMBLE  = 8'hFA;
    localparam logic [7:0] BUSID     = 8'hFF;
    localparam logic [7:0] DATA_MID  = 8'h32;
    localparam logic [7:0] DATA_LEN  = 8'd59;

    // Measurement fields
    localparam logic [4:0] LAST_FIELD  = 5'd16;
    localparam logic [4:0] NUM_FLOATS  = 5'd13;
    localparam logic [4:0] STATUS_FLD  = 5'd15;

    // Default payload store depth
    localparam int unsigned PAYLOAD_DEPTH_DEF = 64;

    // Frame descriptor queue
    localparam int unsigned QDEPTH = 2;
    localparam int unsigned QAW    = 1;

    typedef enum logic [1:0] {
        ST_FIELD = 2'd0,
        ST_CSUM  = 2'd1,
        ST_IDLEN = 2'd2
    } t_status;

    // One finished frame, handed from parser to decoder
    typedef struct packed {
        t_status    status;
        logic [7:0] msg_id;
    } t_desc;

    // Position of the final byte of a field, counted from zero
    function automatic logic [1:0] fld_last_byte(input logic [4:0] idx);
        logic [1:0] r;
        if (idx < NUM_FLOATS) begin
            r = 2'd3;
        end else if (idx == STATUS_FLD) begin
            r = 2'd0;
        end else begin
            r = 2'd1;
        end
        return r;
    endfunction

endpackage

FILE: rtl/core/imu_frx_if.sv
// Handshake channels of the IMU frame receiver: byte input and result output.
`timescale 1ns / 1ps
interface imu_frx_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

interface imu_frx_res_if;
    logic        valid;
    logic        ready;
    logic [1:0]  status;
    logic [7:0]  msg_id;
    logic [4:0]  field_index;
    logic [31:0] field_value;
    logic        last;

    modport source (output valid, output status, output msg_id, output field_index,
                    output field_value, output last, input ready);
    modport sink   (input valid, input status, input msg_id, input field_index,
                    input field_value, input last, output ready);
endinterface

FILE: rtl/core/imu_frame_receiver.sv
// A bad frame yields one status result after its checksum byte is taken and has passed
// through the descriptor queue, the decoder state and the output register; a good frame
// yields its fields instead. Input takes one byte per cycle, but a checksum byte waits
// for queue space and payload bytes of the next frame wait until the decoder has read out
// every good frame, one byte at a time. Reset (i_rst_n low, synchronous) returns to
// preamble hunting and empties the queue and output; the payload store is not cleared.
`timescale 1ns / 1ps
module imu_frame_receiver import imu_frx_pkg::*; #(
    parameter int unsigned PAYLOAD_DEPTH = PAYLOAD_DEPTH_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    imu_frx_byte_if.sink  i_rx,
    imu_frx_res_if.source o_res
);

    localparam int unsigned AW = $clog2(PAYLOAD_DEPTH);

    logic          wr_en;
    logic [AW-1:0] wr_addr;
    logic [7:0]    wr_data;
    logic          push;
    t_desc         push_desc;
    logic          q_ready;
    logic          q_valid;
    t_desc         q_desc;
    logic          q_pop;
    logic          good_done;

    // Parser
    imu_frx_front #(.PAYLOAD_DEPTH(PAYLOAD_DEPTH), .AW(AW)) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_rx.valid),
        .i_byte      (i_rx.rx_byte),
        .o_ready     (i_rx.ready),
        .o_wr_en     (wr_en),
        .o_wr_addr   (wr_addr),
        .o_wr_data   (wr_data),
        .o_push      (push),
        .o_desc      (push_desc),
        .i_q_ready   (q_ready),
        .i_good_done (good_done)
    );

    // Frame descriptor queue
    imu_frx_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_desc  (push_desc),
        .o_ready (q_ready),
        .o_valid (q_valid),
        .o_desc  (q_desc),
        .i_pop   (q_pop)
    );

    // Decoder
    imu_frx_back #(.PAYLOAD_DEPTH(PAYLOAD_DEPTH), .AW(AW)) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_wr_en       (wr_en),
        .i_wr_addr     (wr_addr),
        .i_wr_data     (wr_data),
        .i_q_valid     (q_valid),
        .i_q_desc      (q_desc),
        .o_q_pop       (q_pop),
        .o_good_done   (good_done),
        .o_valid       (o_res.valid),
        .i_ready       (o_res.ready),
        .o_status      (o_res.status),
        .o_msg_id      (o_res.msg_id),
        .o_field_index (o_res.field_index),
        .o_field_value (o_res.field_value),
        .o_last        (o_res.last)
    );

endmodule

FILE: rtl/core/imu_frx_front.sv
// Frame parser: hunts preamble, tracks checksum, stores payload, classifies frames.
`timescale 1ns / 1ps
module imu_frx_front import imu_frx_pkg::*; #(
    parameter int unsigned PAYLOAD_DEPTH = PAYLOAD_DEPTH_DEF,
    parameter int unsigned AW            = $clog2(PAYLOAD_DEPTH)
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    input  logic [7:0]    i_byte,
    output logic          o_ready,
    // payload store write port
    output logic          o_wr_en,
    output logic [AW-1:0] o_wr_addr,
    output logic [7:0]    o_wr_data,
    // descriptor push
    output logic          o_push,
    output t_desc         o_desc,
    input  logic          i_q_ready,
    // decoder finished reading a good frame
    input  logic          i_good_done
);

    typedef enum logic [2:0] {
        PH_HUNT, PH_BUSID, PH_MID, PH_LEN, PH_PAYLOAD, PH_CHECK
    } t_phase;

    t_phase     r_phase;
    logic [7:0] r_byte_count;
    logic [7:0] r_frame_length;
    logic [7:0] r_sum;
    logic [7:0] r_frame_id;
    logic [1:0] r_good_cnt;

    logic       accept;
    logic       store_busy;
    logic [7:0] n_sum;
    logic [7:0] n_byte_count;
    logic       good_push;

    // Payload writes wait until the decoder has read out every good frame
    assign store_busy = (r_good_cnt != 2'd0);

    always_comb begin
        case (r_phase)
            PH_PAYLOAD: o_ready = !store_busy;
            PH_CHECK:   o_ready = i_q_ready;
            default:    o_ready = 1'b1;
        endcase
    end

    assign accept       = i_valid && o_ready;
    assign n_sum        = r_sum + i_byte;
    assign n_byte_count = r_byte_count + 8'd1;

    // Store write, skipped beyond the store depth
    assign o_wr_en   = accept && (r_phase == PH_PAYLOAD)
                       && ({1'b0, r_byte_count} < 9'(PAYLOAD_DEPTH));
    assign o_wr_addr = r_byte_count[AW-1:0];
    assign o_wr_data = i_byte;

    // Frame classification on the checksum byte
    always_comb begin
        o_desc.msg_id = r_frame_id;
        if (n_sum != 8'd0) begin
            o_desc.status = ST_CSUM;
        end else if (r_frame_id != DATA_MID || r_frame_length != DATA_LEN) begin
            o_desc.status = ST_IDLEN;
        end else begin
            o_desc.status = ST_FIELD;
        end
    end

    assign o_push    = accept && (r_phase == PH_CHECK);
    assign good_push = o_push && (o_desc.status == ST_FIELD);

    // Phase machine and frame registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase        <= PH_HUNT;
            r_byte_count   <= 8'd0;
            r_frame_length <= 8'd0;
            r_sum          <= 8'd0;
            r_frame_id     <= 8'd0;
            r_good_cnt     <= 2'd0;
        end else begin
            r_good_cnt <= r_good_cnt + {1'b0, good_push} - {1'b0, i_good_done};
            if (accept) begin
                case (r_phase)
                    PH_HUNT: begin
                        if (i_byte == PREAMBLE) r_phase <= PH_BUSID;
                    end
                    PH_BUSID: begin
                        if (i_byte == BUSID) begin
                            r_sum   <= i_byte;
                            r_phase <= PH_MID;
                        end else begin
                            r_phase <= PH_HUNT;
                        end
                    end
                    PH_MID: begin
                        r_frame_id <= i_byte;
                        r_sum      <= n_sum;
                        r_phase    <= PH_LEN;
                    end
                    PH_LEN: begin
                        r_frame_length <= i_byte;
                        r_byte_count   <= 8'd0;
                        r_sum          <= n_sum;
                        r_phase        <= (i_byte == 8'd0) ? PH_CHECK : PH_PAYLOAD;
                    end
                    PH_PAYLOAD: begin
                        r_sum        <= n_sum;
                        r_byte_count <= n_byte_count;
                        if (n_byte_count == r_frame_length) r_phase <= PH_CHECK;
                    end
                    PH_CHECK: begin
                        r_sum   <= n_sum;
                        r_phase <= PH_HUNT;
                    end
                    default: r_phase <= PH_HUNT;
                endcase
            end
        end
    end

endmodule

FILE: rtl/core/imu_frx_queue.sv
// Small descriptor FIFO between the frame parser and the field decoder.
`timescale 1ns / 1ps
module imu_frx_queue import imu_frx_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_push,
    input  t_desc i_desc,
    output logic  o_ready,
    output logic  o_valid,
    output t_desc o_desc,
    input  logic  i_pop
);

    localparam int unsigned CW = $clog2(QDEPTH + 1);

    t_desc          r_mem [QDEPTH];
    logic [QAW-1:0] r_wp;
    logic [QAW-1:0] r_rp;
    logic [CW-1:0]  r_cnt;

    logic do_push;
    logic do_pop;

    assign o_ready = (r_cnt != CW'(QDEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_desc  = r_mem[r_rp];
    assign do_push = i_push && o_ready;
    assign do_pop  = i_pop && o_valid;

    // Entry storage
    always_ff @(posedge i_clk) begin
        if (do_push) r_mem[r_wp] <= i_desc;
    end

    // Pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) r_wp <= r_wp + QAW'(1);
            if (do_pop)  r_rp <= r_rp + QAW'(1);
            r_cnt <= r_cnt + CW'(do_push) - CW'(do_pop);
        end
    end

endmodule

FILE: rtl/core/imu_frx_back.sv
// Decoder: walks payload store, emits big-endian measurement fields or errors.
`timescale 1ns / 1ps
module imu_frx_back import imu_frx_pkg::*; #(
    parameter int unsigned PAYLOAD_DEPTH = PAYLOAD_DEPTH_DEF,
    parameter int unsigned AW            = $clog2(PAYLOAD_DEPTH)
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    // payload store write port
    input  logic          i_wr_en,
    input  logic [AW-1:0] i_wr_addr,
    input  logic [7:0]    i_wr_data,
    // descriptor pop
    input  logic          i_q_valid,
    input  t_desc         i_q_desc,
    output logic          o_q_pop,
    output logic          o_good_done,
    // result channel
    output logic          o_valid,
    input  logic          i_ready,
    output logic [1:0]    o_status,
    output logic [7:0]    o_msg_id,
    output logic [4:0]    o_field_index,
    output logic [31:0]   o_field_value,
    output logic          o_last
);

    typedef enum logic [1:0] {B_IDLE, B_RD, B_ACC, B_EMIT} t_bstate;

    logic [7:0]  r_store [PAYLOAD_DEPTH];
    logic [7:0]  r_rd_data;

    t_bstate     r_state;
    t_status     r_status;
    logic [7:0]  r_id;
    logic [4:0]  r_idx;
    logic [1:0]  r_bif;
    logic [AW-1:0] r_addr;
    logic [31:0] r_acc;

    logic        r_ov;
    logic [1:0]  r_o_status;
    logic [7:0]  r_o_id;
    logic [4:0]  r_o_idx;
    logic [31:0] r_o_val;
    logic        r_o_last;

    logic        out_free;
    logic        emit_last;
    logic        do_emit;

    assign out_free    = !r_ov || i_ready;
    assign emit_last   = (r_status != ST_FIELD) || (r_idx == LAST_FIELD);
    assign do_emit     = (r_state == B_EMIT) && out_free;
    assign o_q_pop     = (r_state == B_IDLE) && i_q_valid;
    assign o_good_done = do_emit && emit_last && (r_status == ST_FIELD);

    // Payload store: one write port, registered read
    always_ff @(posedge i_clk) begin
        if (i_wr_en) r_store[i_wr_addr] <= i_wr_data;
        if (r_state == B_RD) r_rd_data <= r_store[r_addr];
    end

    // Decoder sequencer and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= B_IDLE;
            r_ov    <= 1'b0;
        end else begin
            // output valid: set on emit, cleared once taken
            if (do_emit) begin
                r_ov <= 1'b1;
            end else if (r_ov && i_ready) begin
                r_ov <= 1'b0;
            end
            case (r_state)
                B_IDLE: begin
                    if (i_q_valid) begin
                        r_status <= i_q_desc.status;
                        r_id     <= i_q_desc.msg_id;
                        r_idx    <= 5'd0;
                        r_bif    <= 2'd0;
                        r_addr   <= '0;
                        r_acc    <= 32'd0;
                        r_state  <= (i_q_desc.status == ST_FIELD) ? B_RD : B_EMIT;
                    end
                end
                B_RD: r_state <= B_ACC;
                B_ACC: begin
                    r_acc  <= {r_acc[23:0], r_rd_data};
                    r_addr <= r_addr + AW'(1);
                    if (r_bif == fld_last_byte(r_idx)) begin
                        r_bif   <= 2'd0;
                        r_state <= B_EMIT;
                    end else begin
                        r_bif   <= r_bif + 2'd1;
                        r_state <= B_RD;
                    end
                end
                B_EMIT: begin
                    if (out_free) begin
                        r_o_status <= r_status;
                        r_o_id     <= r_id;
                        r_o_idx    <= r_idx;
                        r_o_val    <= r_acc;
                        r_o_last   <= emit_last;
                        r_acc      <= 32'd0;
                        r_idx      <= r_idx + 5'd1;
                        r_state    <= emit_last ? B_IDLE : B_RD;
                    end
                end
                default: r_state <= B_IDLE;
            endcase
        end
    end

    assign o_valid       = r_ov;
    assign o_status      = r_o_status;
    assign o_msg_id      = r_o_id;
    assign o_field_index = r_o_idx;
    assign o_field_value = r_o_val;
    assign o_last        = r_o_last;

endmodule

FILE: rtl/core/imu_frx_checker.sv
// Port-level checks on the IMU frame receiver result channel, bound to the top level.
`timescale 1ns / 1ps
module imu_frx_checker import imu_frx_pkg::*; (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_valid,
    input logic        i_ready,
    input logic [1:0]  i_status,
    input logic [7:0]  i_msg_id,
    input logic [4:0]  i_field_index,
    input logic [31:0] i_field_value,
    input logic        i_last
);

    // Error results are single, closing items with empty field
    a_status_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && i_status != ST_FIELD)
            |-> (i_last && i_field_index == 5'd0 && i_field_value == 32'd0))
        else $error("error result not a lone closing item");

    // Decoded fields: last marks exactly the final field (index LAST_FIELD)
    a_field_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && i_status == ST_FIELD) |-> (i_last == (i_field_index == LAST_FIELD)))
        else $error("last flag does not match final field");

    // Stalled result holds
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !i_ready) |=> (i_valid && $stable(i_status) && $stable(i_msg_id)
            && $stable(i_field_index) && $stable(i_field_value) && $stable(i_last)))
        else $error("stalled result changed");

endmodule

bind imu_frame_receiver imu_frx_checker u_imu_frx_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_valid       (o_res.valid),
    .i_ready       (o_res.ready),
    .i_status      (o_res.status),
    .i_msg_id      (o_res.msg_id),
    .i_field_index (o_res.field_index),
    .i_field_value (o_res.field_value),
    .i_last        (o_res.last)
);
